/* hdl/vapt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve actuator position tracker: shared definitions
// Opcodes of the input word, the valve state encoding, field widths and the threshold reset value.
// ----------------------------------------------------------------------------
package vapt_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_POWER  = 2'd1,
    OP_DIR    = 2'd2,
    OP_SAMPLE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_OPENING = 3'd2,
    ST_OPENED  = 3'd3,
    ST_CLOSING = 3'd4
  } valve_state_e;

  localparam int unsigned OpBits    = 2;
  localparam int unsigned StateBits = 3;

  // Reset value of the current threshold in milliamps.
  localparam int unsigned ThresholdReset = 50;

endpackage

/* hdl/valve_actuator_position_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve actuator position tracker
// An accepted input word is held in the input register, passes through the
// core logic, and its result is registered in the output register.
// Throughput: one word per cycle while results are taken. While the output
// side holds off, one more word is taken into the input register, then the
// input stalls until the result register drains.
// Reset (asynchronous, active low) sets the valve state to unknown, clears
// relays, peak current and timers, and loads the threshold with 50 mA.
// ----------------------------------------------------------------------------
module valve_actuator_position_tracker
  import vapt_pkg::*;
#(
  parameter int unsigned CURRENT_BITS = 12,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CURRENT_BITS-1:0] cfg_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // relay_on, current_ma
  input  logic [((CURRENT_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic [OpBits-1:0]       s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // valve_state, state_changed, peak_current_ma, actuation_time_ms
  output logic [((StateBits+1+CURRENT_BITS+TIME_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned ResBits  = StateBits + 1 + CURRENT_BITS + TIME_BITS;
  localparam int unsigned OutBytes = (ResBits + 7) / 8;
  localparam int unsigned OutBits  = OutBytes * 8;

  op_e                     item_opcode;
  logic                    item_relay_on;
  logic [CURRENT_BITS-1:0] item_current_ma;
  logic                    item_valid;
  logic                    item_take;
  logic                    res_ready;
  valve_state_e            res_state;
  logic                    res_changed;
  logic [CURRENT_BITS-1:0] res_peak;
  logic [TIME_BITS-1:0]    res_time;
  logic [OutBits-1:0]      res_data;

  assign cfg_ready = 1'b1;
  assign item_take = item_valid && res_ready;

  vapt_in_reg #(
    .CURRENT_BITS(CURRENT_BITS)
  ) u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (op_e'(s_axis_tuser)),
    .relay_on_i  (s_axis_tdata[0]),
    .current_ma_i(s_axis_tdata[CURRENT_BITS:1]),
    .item_valid_o(item_valid),
    .item_take_i (item_take),
    .opcode_o    (item_opcode),
    .relay_on_o  (item_relay_on),
    .current_ma_o(item_current_ma)
  );

  vapt_core #(
    .CURRENT_BITS(CURRENT_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid && cfg_ready),
    .cfg_data_i         (cfg_data),
    .step_i             (item_take),
    .opcode_i           (item_opcode),
    .relay_on_i         (item_relay_on),
    .current_ma_i       (item_current_ma),
    .valve_state_o      (res_state),
    .state_changed_o    (res_changed),
    .peak_current_ma_o  (res_peak),
    .actuation_time_ms_o(res_time)
  );

  assign res_data = OutBits'({res_time, res_peak, res_changed, res_state});

  vapt_out_reg #(
    .DATA_BITS(OutBits)
  ) u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(item_valid),
    .res_ready_o(res_ready),
    .res_data_i (res_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

/* hdl/vapt_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted word until the tracker core consumes it.
// ----------------------------------------------------------------------------
module vapt_in_reg
  import vapt_pkg::*;
#(
  parameter int unsigned CURRENT_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  op_e                     opcode_i,
  input  logic                    relay_on_i,
  input  logic [CURRENT_BITS-1:0] current_ma_i,
  output logic                    item_valid_o,
  input  logic                    item_take_i,
  output op_e                     opcode_o,
  output logic                    relay_on_o,
  output logic [CURRENT_BITS-1:0] current_ma_o
);

  logic                    valid_q, valid_d;
  op_e                     opcode_q;
  logic                    relay_on_q;
  logic [CURRENT_BITS-1:0] current_ma_q;
  logic                    load;

  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      opcode_q     <= opcode_i;
      relay_on_q   <= relay_on_i;
      current_ma_q <= current_ma_i;
    end
  end

  assign item_valid_o = valid_q;
  assign opcode_o     = opcode_q;
  assign relay_on_o   = relay_on_q;
  assign current_ma_o = current_ma_q;

endmodule

/* hdl/vapt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker core
// Valve state, relay levels, peak current and timers, updated once per word.
// ----------------------------------------------------------------------------
module vapt_core
  import vapt_pkg::*;
#(
  parameter int unsigned CURRENT_BITS = 12,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CURRENT_BITS-1:0] cfg_data_i,
  input  logic                    step_i,
  input  op_e                     opcode_i,
  input  logic                    relay_on_i,
  input  logic [CURRENT_BITS-1:0] current_ma_i,
  output valve_state_e            valve_state_o,
  output logic                    state_changed_o,
  output logic [CURRENT_BITS-1:0] peak_current_ma_o,
  output logic [TIME_BITS-1:0]    actuation_time_ms_o
);

  logic [CURRENT_BITS-1:0] threshold_q;
  valve_state_e            state_q, state_d;
  logic                    power_q, power_d;
  logic                    dir_q, dir_d;
  logic [CURRENT_BITS-1:0] peak_q, peak_d;
  logic [TIME_BITS-1:0]    elapsed_q, elapsed_d;
  logic [TIME_BITS-1:0]    actuation_q, actuation_d;
  logic                    enter;
  valve_state_e            target;
  logic                    changed;

  always_comb begin
    state_d     = state_q;
    power_d     = power_q;
    dir_d       = dir_q;
    peak_d      = peak_q;
    elapsed_d   = elapsed_q;
    actuation_d = actuation_q;
    enter       = 1'b0;
    target      = dir_q ? ST_OPENING : ST_CLOSING;

    case (opcode_i)
      OP_TICK: begin
        if (elapsed_q != {TIME_BITS{1'b1}}) begin
          elapsed_d = elapsed_q + {{(TIME_BITS-1){1'b0}}, 1'b1};
        end
      end
      OP_POWER: begin
        if (relay_on_i != power_q) begin
          power_d = relay_on_i;
          if (relay_on_i) begin
            peak_d      = '0;
            actuation_d = '0;
            enter       = 1'b1;
          end
        end
      end
      OP_DIR: begin
        if (relay_on_i != dir_q) begin
          dir_d  = relay_on_i;
          target = relay_on_i ? ST_OPENING : ST_CLOSING;
          enter  = power_q;
        end
      end
      OP_SAMPLE: begin
        if (current_ma_i >= threshold_q) begin
          if (current_ma_i > peak_q) begin
            peak_d = current_ma_i;
          end
          actuation_d = elapsed_q;
          enter       = 1'b1;
        end else if (state_q == ST_OPENING) begin
          actuation_d = elapsed_q;
          target      = ST_OPENED;
          enter       = 1'b1;
        end else if (state_q == ST_CLOSING) begin
          actuation_d = elapsed_q;
          target      = ST_CLOSED;
          enter       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Entering the state the valve is already in is not a change.
    changed = enter && (target != state_q);
    if (changed) begin
      state_d   = target;
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= CURRENT_BITS'(ThresholdReset);
      state_q     <= ST_UNKNOWN;
      power_q     <= 1'b0;
      dir_q       <= 1'b0;
      peak_q      <= '0;
      elapsed_q   <= '0;
      actuation_q <= '0;
    end else begin
      if (cfg_we_i) begin
        threshold_q <= cfg_data_i;
      end
      if (step_i) begin
        state_q     <= state_d;
        power_q     <= power_d;
        dir_q       <= dir_d;
        peak_q      <= peak_d;
        elapsed_q   <= elapsed_d;
        actuation_q <= actuation_d;
      end
    end
  end

  // The result carries the state after this word.
  assign valve_state_o       = state_d;
  assign state_changed_o     = changed;
  assign peak_current_ma_o   = peak_d;
  assign actuation_time_ms_o = actuation_d;

endmodule

/* hdl/vapt_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module vapt_out_reg #(
  parameter int unsigned DATA_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  output logic                 res_ready_o,
  input  logic [DATA_BITS-1:0] res_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_BITS-1:0] out_data_o
);

  logic                 valid_q, valid_d;
  logic [DATA_BITS-1:0] data_q;
  logic                 load;

  assign res_ready_o = !valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve actuator position tracker testbench
// Drives relay, tick and current-sample words into the tracker, predicts each
// result word with a behavioral copy of the tracker, and checks every result
// field by field. Covers directed corner cases, threshold extremes, a long
// output hold-off and random words with random gaps on both sides, about 1400
// words in all.
// ----------------------------------------------------------------------------
module testbench;
  import vapt_pkg::*;

  localparam int unsigned CurW  = 12;
  localparam int unsigned TimeW = 32;
  localparam int unsigned InW   = ((CurW + 1 + 7) / 8) * 8;
  localparam int unsigned OutW  = ((StateBits + 1 + CurW + TimeW + 7) / 8) * 8;
  localparam int unsigned LongHoldCycles = 300;

  typedef struct packed {
    valve_state_e      vstate;
    logic              changed;
    logic [CurW-1:0]   peak_ma;
    logic [TimeW-1:0]  act_ms;
  } valve_reading_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CurW-1:0]    cfg_data;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // relay_on, current_ma
  logic [InW-1:0]     s_axis_tdata;
  // opcode
  logic [OpBits-1:0]  s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // valve_state, state_changed, peak_current_ma, actuation_time_ms
  logic [OutW-1:0]    m_axis_tdata;

  // Tracker state as the testbench believes it to be.
  logic [CurW-1:0]    threshold_ma;
  valve_state_e       valve_now;
  logic               power_on;
  logic               dir_open;
  logic [CurW-1:0]    peak_ma;
  logic [TimeW-1:0]   elapsed_ms;
  logic [TimeW-1:0]   act_ms;

  valve_reading_t     pending_readings[$];
  int unsigned        error_count;
  int unsigned        words_sent;
  bit                 gaps_on;
  bit                 long_hold_req;

  valve_actuator_position_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic valve_state_e motion_state();
    return dir_open ? ST_OPENING : ST_CLOSING;
  endfunction

  function automatic logic enter_state(valve_state_e next_state);
    if (next_state == valve_now) return 1'b0;
    valve_now  = next_state;
    elapsed_ms = '0;
    return 1'b1;
  endfunction

  task automatic track_word(op_e op, logic level, logic [CurW-1:0] ma);
    logic changed;
    changed = 1'b0;
    case (op)
      OP_TICK: begin
        if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
      end
      OP_POWER: begin
        if (level != power_on) begin
          power_on = level;
          if (level) begin
            peak_ma = '0;
            act_ms  = '0;
            changed = enter_state(motion_state());
          end
        end
      end
      OP_DIR: begin
        if (level != dir_open) begin
          dir_open = level;
          if (power_on) changed = enter_state(motion_state());
        end
      end
      default: begin
        if (ma >= threshold_ma) begin
          if (ma > peak_ma) peak_ma = ma;
          // The elapsed count is taken before the state change clears it.
          act_ms  = elapsed_ms;
          changed = enter_state(motion_state());
        end else if (valve_now == ST_OPENING) begin
          act_ms  = elapsed_ms;
          changed = enter_state(ST_OPENED);
        end else if (valve_now == ST_CLOSING) begin
          act_ms  = elapsed_ms;
          changed = enter_state(ST_CLOSED);
        end
      end
    endcase
    pending_readings.push_back('{vstate: valve_now, changed: changed,
                                 peak_ma: peak_ma, act_ms: act_ms});
  endtask

  task automatic send_word(op_e op, logic level, logic [CurW-1:0] ma);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InW - CurW - 1){1'b0}}, ma, level};
    do @(posedge clk_i); while (!s_axis_tready);
    track_word(op, level, ma);
    words_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  // Only written once every result is back, so the tracker is idle.
  task automatic write_threshold(logic [CurW-1:0] value);
    stop_sending();
    wait_drained();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    threshold_ma = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CurW-1:0] moving_ma();
    return CurW'($urandom_range(2 ** CurW - 1, threshold_ma));
  endfunction

  task automatic test_directed();
    gaps_on = 1'b1;
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_SAMPLE, 1'b0, 12'd49);    // quiet while unknown
    send_word(OP_SAMPLE, 1'b0, 12'd50);    // moving with power off
    send_word(OP_POWER, 1'b0, '0);         // same level, nothing happens
    send_word(OP_DIR, 1'b0, '0);
    send_word(OP_POWER, 1'b1, '0);
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_TICK, 1'b1, '1);
    send_word(OP_SAMPLE, 1'b0, '1);
    send_word(OP_DIR, 1'b1, '0);           // direction change while powered
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_SAMPLE, 1'b0, '0);        // reaches the end stop
    send_word(OP_SAMPLE, 1'b1, '0);        // quiet while not moving
    send_word(OP_POWER, 1'b0, '0);
    send_word(OP_DIR, 1'b0, '0);           // stored only, power is off
    send_word(OP_POWER, 1'b1, '1);
    send_word(OP_SAMPLE, 1'b0, 12'd1000);
    send_word(OP_TICK, 1'b0, '0);
    send_word(OP_SAMPLE, 1'b0, 12'd50);
    send_word(OP_SAMPLE, 1'b0, 12'd49);
    send_word(OP_POWER, 1'b1, '0);
    send_word(OP_DIR, 1'b1, '0);           // closing to opening
    send_word(OP_DIR, 1'b0, '0);           // and back
    send_word(OP_POWER, 1'b0, '1);
    stop_sending();
  endtask

  task automatic test_threshold_extremes();
    write_threshold('0);
    send_word(OP_POWER, 1'b1, '0);
    send_word(OP_SAMPLE, 1'b0, '0);        // zero current still counts as moving
    send_word(OP_POWER, 1'b0, '0);
    write_threshold('1);
    send_word(OP_DIR, 1'b1, '0);
    send_word(OP_POWER, 1'b1, '0);
    send_word(OP_SAMPLE, 1'b0, 12'd4094);
    send_word(OP_POWER, 1'b0, '0);
    send_word(OP_POWER, 1'b1, '0);
    send_word(OP_SAMPLE, 1'b0, '1);
    send_word(OP_SAMPLE, 1'b0, 12'd4094);
    send_word(OP_POWER, 1'b0, '0);
    write_threshold(12'(ThresholdReset));
  endtask

  // The output side holds off while words keep coming, so the tracker
  // fills up and has to stall its input.
  task automatic test_output_backpressure();
    stop_sending();
    wait_drained();
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    send_word(OP_POWER, 1'b1, '0);
    repeat (30) begin
      send_word(op_e'($urandom_range(3)), 1'($urandom), 12'($urandom));
    end
    send_word(OP_POWER, 1'b0, '0);
    gaps_on = 1'b1;
    stop_sending();
  endtask

  // Mostly complete actuation cycles with random content, the rest noise.
  task automatic run_random_words(int unsigned count);
    int unsigned target;
    int unsigned n;
    target = words_sent + count;
    while (words_sent < target) begin
      gaps_on = ($urandom_range(3) != 0);
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(1)) send_word(OP_DIR, 1'($urandom), 12'($urandom));
        send_word(OP_POWER, 1'b1, 12'($urandom));
        n = $urandom_range(12, 1);
        repeat (n) begin
          if ($urandom_range(1)) begin
            repeat ($urandom_range(($urandom_range(9) == 0) ? 200 : 15)) begin
              send_word(OP_TICK, 1'($urandom), 12'($urandom));
            end
          end
          send_word(OP_SAMPLE, 1'($urandom), moving_ma());
          if ($urandom_range(9) == 0) send_word(OP_DIR, 1'($urandom), 12'($urandom));
        end
        repeat ($urandom_range(5)) send_word(OP_TICK, 1'b0, '0);
        if (threshold_ma != '0) begin
          send_word(OP_SAMPLE, 1'($urandom),
                    CurW'($urandom_range(threshold_ma - 1'b1, 0)));
        end
        if ($urandom_range(3) == 0) send_word(OP_SAMPLE, 1'b0, 12'($urandom));
        send_word(OP_POWER, 1'b0, 12'($urandom));
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_word(op_e'($urandom_range(3)), 1'($urandom), 12'($urandom));
        end
      end
    end
    stop_sending();
  endtask

  // Each run overshoots its count by the rest of the actuation cycle in
  // progress, so the counts are kept a little low.
  task automatic test_random_thresholds();
    run_random_words(220);
    write_threshold('0);
    run_random_words(220);
    write_threshold('1);
    run_random_words(160);
    write_threshold(12'd1);
    run_random_words(160);
    repeat (2) begin
      write_threshold(12'($urandom_range(4094, 1)));
      run_random_words(170);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    valve_reading_t want;
    valve_reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.vstate  = valve_state_e'(m_axis_tdata[StateBits-1:0]);
      got.changed = m_axis_tdata[StateBits];
      got.peak_ma = m_axis_tdata[StateBits+1 +: CurW];
      got.act_ms  = m_axis_tdata[StateBits+1+CurW +: TimeW];
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (got.vstate != want.vstate) begin
          $display("%0t: valve_state expected %0d, got %0d", $time, want.vstate,
                   got.vstate);
          error_count++;
        end
        if (got.changed != want.changed) begin
          $display("%0t: state_changed expected %0d, got %0d", $time, want.changed,
                   got.changed);
          error_count++;
        end
        if (got.peak_ma != want.peak_ma) begin
          $display("%0t: peak_current_ma expected %0d, got %0d", $time,
                   want.peak_ma, got.peak_ma);
          error_count++;
        end
        if (got.act_ms != want.act_ms) begin
          $display("%0t: actuation_time_ms expected %0d, got %0d", $time,
                   want.act_ms, got.act_ms);
          error_count++;
        end
      end
    end
  end

  initial begin : result_receiver
    int unsigned hold;
    forever begin
      hold = long_hold_req ? LongHoldCycles : pick_gap();
      long_hold_req = 1'b0;
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #20ms;
    $display("testbench failed");
    $finish;
  end

  initial begin : main
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    error_count   = 0;
    words_sent    = 0;
    gaps_on       = 1'b1;
    long_hold_req = 1'b0;
    threshold_ma  = 12'(ThresholdReset);
    valve_now     = ST_UNKNOWN;
    power_on      = 1'b0;
    dir_open      = 1'b0;
    peak_ma       = '0;
    elapsed_ms    = '0;
    act_ms        = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_thresholds();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/vapt_pkg.sv
hdl/vapt_in_reg.sv
hdl/vapt_core.sv
hdl/vapt_out_reg.sv
hdl/valve_actuator_position_tracker.sv
test/testbench.sv
